// ===== design/udlc_pkg.sv =====
// ----------------------------------------------------------------------------
// udlc_pkg
// Shared types and constants for the diff line classifier.
// ----------------------------------------------------------------------------
package udlc_pkg;

    localparam int UDLC_MAX_MARKER_COLUMNS = 15;
    localparam int UDLC_FIFO_DEPTH         = 4;

    // line kinds
    localparam logic [2:0] KIND_HUNK    = 3'd0;
    localparam logic [2:0] KIND_CONTEXT = 3'd1;
    localparam logic [2:0] KIND_ADDED   = 3'd2;
    localparam logic [2:0] KIND_REMOVED = 3'd3;
    localparam logic [2:0] KIND_SUMMARY = 3'd4;

    localparam logic [31:0] NO_NUM   = 32'hFFFF_FFFF;
    localparam logic [30:0] NUM_MAX  = 31'h7FFF_FFFF;
    localparam logic [30:0] ACC_STOP = 31'd1000000000;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_G     = 8'h47;

    localparam int PAT_BIN_LEN = 13;
    localparam int PAT_GIT_LEN = 16;

    localparam logic [7:0] PAT_BIN [PAT_BIN_LEN] = '{
        8'h42, 8'h69, 8'h6E, 8'h61, 8'h72, 8'h79, 8'h20,
        8'h66, 8'h69, 8'h6C, 8'h65, 8'h73, 8'h20
    };
    localparam logic [7:0] PAT_GIT [PAT_GIT_LEN] = '{
        8'h47, 8'h49, 8'h54, 8'h20, 8'h62, 8'h69, 8'h6E, 8'h61,
        8'h72, 8'h79, 8'h20, 8'h70, 8'h61, 8'h74, 8'h63, 8'h68
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } udlc_in_t;

    typedef struct packed {
        logic [2:0]         line_kind;
        logic signed [31:0] old_line;
        logic signed [31:0] new_line;
        logic [31:0]        text_start;
        logic [31:0]        text_length;
        logic               is_binary;
        logic               last_result;
    } udlc_out_t;

    // results produced by one accepted byte
    typedef struct packed {
        logic [1:0] count;
        udlc_out_t  r0;
        udlc_out_t  r1;
    } udlc_push_t;

endpackage

// ===== design/udlc_core.sv =====
// ----------------------------------------------------------------------------
// udlc_core
// Per-byte line state, hunk header scan, line classification.
// ----------------------------------------------------------------------------
module udlc_core
    import udlc_pkg::*;
#(
    parameter int MAX_MARKER_COLUMNS = UDLC_MAX_MARKER_COLUMNS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  udlc_in_t   item,
    output udlc_push_t push
);

    localparam int MW = $clog2(MAX_MARKER_COLUMNS + 1);

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_NOHDR     = 3'd1;
    localparam logic [2:0] PH_SCAN      = 3'd2;
    localparam logic [2:0] PH_OLD_FIRST = 3'd3;
    localparam logic [2:0] PH_OLD_DIG   = 3'd4;
    localparam logic [2:0] PH_NEW_FIRST = 3'd5;
    localparam logic [2:0] PH_NEW_DIG   = 3'd6;
    localparam logic [2:0] PH_DONE      = 3'd7;

    logic [31:0] bo_reg, bo_next, ls_reg, ls_next, lp_reg, lp_next, cr_reg, cr_next;
    logic [15:0] ftc_reg, ftc_next;
    logic [4:0]  at_reg, at_next;
    logic [2:0]  ph_reg, ph_next;
    logic [30:0] oa_reg, oa_next, na_reg, na_next, oc_reg, oc_next, nc_reg, nc_next;
    logic        ih_reg, ih_next, pm_reg, pm_next, pp_reg, pp_next;
    logic [MW-1:0] mcc_reg, mcc_next;
    logic [3:0]  mb_reg, mb_next;
    logic [4:0]  mg_reg, mg_next;
    logic        bs_reg, bs_next;

    function automatic logic [2:0] scan_ph(input logic [7:0] ch, input logic pm);
        logic [2:0] r;
        if (ch == CH_MINUS && !pm)
            r = PH_OLD_FIRST;
        else if (ch == CH_PLUS)
            r = PH_NEW_FIRST;
        else
            r = PH_SCAN;
        return r;
    endfunction

    // times ten plus digit, frozen at 1e9, saturating
    function automatic logic [30:0] accum(input logic [30:0] acc, input logic [7:0] ch);
        logic [34:0] v;
        logic [30:0] r;
        v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {31'd0, ch[3:0]};
        if (acc >= ACC_STOP)
            r = acc;
        else if (v > {4'd0, NUM_MAX})
            r = NUM_MAX;
        else
            r = v[30:0];
        return r;
    endfunction

    function automatic logic [30:0] sat_inc(input logic [30:0] v);
        return (v == NUM_MAX) ? NUM_MAX : v + 31'd1;
    endfunction

    function automatic udlc_out_t mk(input logic [2:0] k, input logic [31:0] o,
                                     input logic [31:0] n, input logic [31:0] ts,
                                     input logic [31:0] tl, input logic b);
        udlc_out_t r;
        r.line_kind   = k;
        r.old_line    = o;
        r.new_line    = n;
        r.text_start  = ts;
        r.text_length = tl;
        r.is_binary   = b;
        r.last_result = 1'b0;
        return r;
    endfunction

    always_comb
    begin
        logic [7:0]  c;
        logic        lst, is_nl, dig, lr_ok;
        logic [31:0] p, e_lp, e_cr, len, st, m32, ts, tl;
        logic [15:0] e_ftc;
        logic [4:0]  e_at, m5;
        logic [2:0]  e_ph;
        logic [30:0] e_oa, e_na;
        logic        e_pm, e_pp, ok;
        logic [7:0]  c0;
        udlc_out_t   lr, sm;

        c     = item.data_byte;
        lst   = item.end_of_input;
        is_nl = (c == CH_LF);
        dig   = (c >= CH_ZERO) && (c <= CH_NINE);
        p     = lp_reg;

        bo_next = bo_reg; ls_next = ls_reg; lp_next = lp_reg; cr_next = cr_reg;
        ftc_next = ftc_reg; at_next = at_reg; ph_next = ph_reg;
        oa_next = oa_reg; na_next = na_reg; oc_next = oc_reg; nc_next = nc_reg;
        ih_next = ih_reg; pm_next = pm_reg; pp_next = pp_reg; mcc_next = mcc_reg;
        mb_next = mb_reg; mg_next = mg_reg; bs_next = bs_reg;
        lr_ok = 1'b0;
        lr = mk(KIND_HUNK, NO_NUM, NO_NUM, 32'd0, 32'd0, 1'b0);
        ok = 1'b0; m5 = 5'd0; ts = 32'd0; tl = 32'd0;

        // binary marker matchers
        if (mb_reg < 4'(PAT_BIN_LEN) && PAT_BIN[mb_reg] == c)
            mb_next = mb_reg + 4'd1;
        else
            mb_next = (c == CH_B) ? 4'd1 : 4'd0;
        if (mb_next >= 4'(PAT_BIN_LEN))
        begin
            bs_next = 1'b1;
            mb_next = 4'd0;
        end
        if (mg_reg < 5'(PAT_GIT_LEN) && PAT_GIT[mg_reg[3:0]] == c)
            mg_next = mg_reg + 5'd1;
        else
            mg_next = (c == CH_G) ? 5'd1 : 5'd0;
        if (mg_next >= 5'(PAT_GIT_LEN))
        begin
            bs_next = 1'b1;
            mg_next = 5'd0;
        end

        // per-character update of the open line
        if (!is_nl)
        begin
            if (p == 32'd0)
                ftc_next = {8'd0, c};
            else if (p == 32'd1)
                ftc_next = {c, ftc_reg[7:0]};
            if (lp_reg != 32'hFFFF_FFFF)
                lp_next = lp_reg + 32'd1;
            if (c == CH_CR)
            begin
                if (cr_reg != 32'hFFFF_FFFF)
                    cr_next = cr_reg + 32'd1;
            end
            else
                cr_next = 32'd0;

            case (ph_reg)
                PH_IDLE:
                begin
                    if (c == CH_AT)
                    begin
                        if (at_reg != 5'd31)
                            at_next = at_reg + 5'd1;
                    end
                    else if (at_reg >= 5'd2)
                        ph_next = scan_ph(c, pm_reg);
                    else
                        ph_next = PH_NOHDR;
                end
                PH_SCAN:
                    ph_next = scan_ph(c, pm_reg);
                PH_OLD_FIRST:
                begin
                    if (dig)
                    begin
                        oa_next = {27'd0, c[3:0]};
                        ph_next = PH_OLD_DIG;
                    end
                    else
                        ph_next = scan_ph(c, pm_reg);
                end
                PH_OLD_DIG:
                begin
                    if (dig)
                        oa_next = accum(oa_reg, c);
                    else
                    begin
                        pm_next = 1'b1;
                        ph_next = scan_ph(c, 1'b1);
                    end
                end
                PH_NEW_FIRST:
                begin
                    if (dig)
                    begin
                        na_next = {27'd0, c[3:0]};
                        ph_next = PH_NEW_DIG;
                    end
                    else
                        ph_next = scan_ph(c, pm_reg);
                end
                PH_NEW_DIG:
                begin
                    if (dig)
                        na_next = accum(na_reg, c);
                    else
                    begin
                        pp_next = 1'b1;
                        ph_next = PH_DONE;
                    end
                end
                default:
                    ph_next = ph_reg;
            endcase

            // combined diff: look for markers in the leading columns
            if (ph_next == PH_NOHDR && p < 32'(mcc_reg))
            begin
                if (c == CH_MINUS)
                    pm_next = 1'b1;
                else if (c == CH_PLUS)
                    pp_next = 1'b1;
            end
        end

        // line being closed: registered state on LF, updated state on a final byte
        e_lp  = is_nl ? lp_reg  : lp_next;
        e_cr  = is_nl ? cr_reg  : cr_next;
        e_ftc = is_nl ? ftc_reg : ftc_next;
        e_at  = is_nl ? at_reg  : at_next;
        e_ph  = is_nl ? ph_reg  : ph_next;
        e_oa  = is_nl ? oa_reg  : oa_next;
        e_na  = is_nl ? na_reg  : na_next;
        e_pm  = is_nl ? pm_reg  : pm_next;
        e_pp  = is_nl ? pp_reg  : pp_next;
        len   = e_lp - e_cr;
        st    = ls_reg;
        c0    = e_ftc[7:0];
        m32   = 32'(mcc_reg);

        if (is_nl || lst)
        begin
            if (e_at >= 5'd2)
            begin
                if (e_ph == PH_OLD_DIG)
                    e_pm = 1'b1;
                if (e_ph == PH_NEW_DIG)
                    e_pp = 1'b1;
                ok = e_pm && e_pp;
                m5 = e_at - 5'd1;
                mcc_next = '0;
                if (ok && e_at >= 5'd3)
                    mcc_next = (32'(m5) > 32'(MAX_MARKER_COLUMNS)) ?
                               MW'(MAX_MARKER_COLUMNS) : MW'(m5);
                if (ok)
                begin
                    oc_next = e_oa;
                    nc_next = e_na;
                end
                ih_next = 1'b1;
                lr = mk(KIND_HUNK, NO_NUM, NO_NUM, st, len, 1'b0);
                lr_ok = 1'b1;
            end
            else if (ih_reg && len != 32'd0 && c0 != CH_BSL)
            begin
                lr_ok = 1'b1;
                if (mcc_reg != '0)
                begin
                    ts = st + ((len < m32) ? len : m32);
                    tl = (len > m32) ? len - m32 : 32'd0;
                    if (e_pm)
                    begin
                        lr = mk(KIND_REMOVED, {1'b0, oc_reg}, NO_NUM, ts, tl, 1'b0);
                        oc_next = sat_inc(oc_reg);
                    end
                    else if (e_pp)
                    begin
                        lr = mk(KIND_ADDED, NO_NUM, {1'b0, nc_reg}, ts, tl, 1'b0);
                        nc_next = sat_inc(nc_reg);
                    end
                    else
                    begin
                        lr = mk(KIND_CONTEXT, {1'b0, oc_reg}, {1'b0, nc_reg}, ts, tl, 1'b0);
                        oc_next = sat_inc(oc_reg);
                        nc_next = sat_inc(nc_reg);
                    end
                end
                else if (c0 == CH_PLUS)
                begin
                    lr = mk(KIND_ADDED, NO_NUM, {1'b0, nc_reg}, st + 32'd1, len - 32'd1,
                            1'b0);
                    nc_next = sat_inc(nc_reg);
                end
                else if (c0 == CH_MINUS)
                begin
                    lr = mk(KIND_REMOVED, {1'b0, oc_reg}, NO_NUM, st + 32'd1, len - 32'd1,
                            1'b0);
                    oc_next = sat_inc(oc_reg);
                end
                else
                begin
                    if (c0 == CH_SPACE)
                        lr = mk(KIND_CONTEXT, {1'b0, oc_reg}, {1'b0, nc_reg}, st + 32'd1,
                                len - 32'd1, 1'b0);
                    else
                        lr = mk(KIND_CONTEXT, {1'b0, oc_reg}, {1'b0, nc_reg}, st, len,
                                1'b0);
                    oc_next = sat_inc(oc_reg);
                    nc_next = sat_inc(nc_reg);
                end
            end
            // fresh line
            lp_next = 32'd0; cr_next = 32'd0; ftc_next = 16'd0; at_next = 5'd0;
            ph_next = PH_IDLE; oa_next = 31'd0; na_next = 31'd0;
            pm_next = 1'b0; pp_next = 1'b0;
        end

        if (is_nl)
            ls_next = bo_reg + 32'd1;
        bo_next = bo_reg + 32'd1;

        sm = mk(KIND_SUMMARY, NO_NUM, NO_NUM, 32'd0, 32'd0, bs_next);
        sm.last_result = 1'b1;

        push.count = '0;
        push.r0 = lr;
        push.r1 = sm;
        if (lr_ok && lst)
            push.count = 2'd2;
        else if (lr_ok)
        begin
            push.count = 2'd1;
            push.r0.last_result = 1'b1;
        end
        else if (lst)
        begin
            push.count = 2'd1;
            push.r0 = sm;
        end
        if (!accept)
            push.count = '0;

        // end of diff: everything back to reset
        if (lst)
        begin
            bo_next = 32'd0; ls_next = 32'd0; oc_next = 31'd0; nc_next = 31'd0;
            ih_next = 1'b0; mcc_next = '0; mb_next = 4'd0; mg_next = 5'd0;
            bs_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bo_reg <= '0; ls_reg <= '0; lp_reg <= '0; cr_reg <= '0;
            ftc_reg <= '0; at_reg <= '0; ph_reg <= PH_IDLE;
            oa_reg <= '0; na_reg <= '0; oc_reg <= '0; nc_reg <= '0;
            ih_reg <= 1'b0; pm_reg <= 1'b0; pp_reg <= 1'b0; mcc_reg <= '0;
            mb_reg <= '0; mg_reg <= '0; bs_reg <= 1'b0;
        end
        else if (accept)
        begin
            bo_reg <= bo_next; ls_reg <= ls_next; lp_reg <= lp_next; cr_reg <= cr_next;
            ftc_reg <= ftc_next; at_reg <= at_next; ph_reg <= ph_next;
            oa_reg <= oa_next; na_reg <= na_next; oc_reg <= oc_next; nc_reg <= nc_next;
            ih_reg <= ih_next; pm_reg <= pm_next; pp_reg <= pp_next; mcc_reg <= mcc_next;
            mb_reg <= mb_next; mg_reg <= mg_next; bs_reg <= bs_next;
        end
    end

endmodule

// ===== design/udlc_fifo.sv =====
// ----------------------------------------------------------------------------
// udlc_fifo
// Result queue: takes up to two records per cycle, hands out one per cycle unless stalled.
// ----------------------------------------------------------------------------
module udlc_fifo
    import udlc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  udlc_push_t push,
    output logic       full,
    output logic [$clog2(UDLC_FIFO_DEPTH):0] level,
    output logic       valid,
    input  logic       stall,
    output udlc_out_t  data
);

    localparam int AW = $clog2(UDLC_FIFO_DEPTH);

    udlc_out_t mem_reg [UDLC_FIFO_DEPTH];
    logic [AW-1:0] wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          pop;

    assign valid = (cnt_reg != '0);
    assign data  = mem_reg[rptr_reg];
    assign pop   = valid && !stall;
    // room for two records is needed before the next byte transfer
    assign full  = (cnt_reg > (AW+1)'(UDLC_FIFO_DEPTH - 2));
    assign level = cnt_reg;

    always_comb
    begin
        wptr_next = wptr_reg + AW'(push.count);
        rptr_next = rptr_reg + AW'(pop);
        cnt_next  = cnt_reg + (AW+1)'(push.count) - (AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wptr_reg] <= push.r0;
        if (push.count == 2'd2)
            mem_reg[wptr_reg + AW'(1)] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== design/unified_diff_line_classifier.sv =====
// ----------------------------------------------------------------------------
// unified_diff_line_classifier
// Splits a diff byte stream into lines and reports hunk and body records.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  byte    | in  | byte_valid/byte_stall | udlc_in_t  (data_byte, end_of_input)
//  rec     | out | rec_valid/rec_stall   | udlc_out_t (one line record)
//
//  one byte per cycle while byte_stall is low; a byte's records enter the
//  result queue at the edge of its transfer, then leave it one record per
//  cycle while rec_stall is low; a byte yields at most two records (closing
//  line plus end summary); byte_stall rises while the queue has room for
//  fewer than two records; reset clears all line state and empties the
//  queue; end of input also returns the line state to reset
// ----------------------------------------------------------------------------
module unified_diff_line_classifier
    import udlc_pkg::*;
#(
    parameter int MAX_MARKER_COLUMNS = UDLC_MAX_MARKER_COLUMNS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  udlc_in_t  byte_data,
    output logic      rec_valid,
    input  logic      rec_stall,
    output udlc_out_t rec_data
);

    logic       accept;
    udlc_push_t push;
    logic [$clog2(UDLC_FIFO_DEPTH):0] level;

    assign accept = byte_valid && !byte_stall;

    udlc_core #(
        .MAX_MARKER_COLUMNS(MAX_MARKER_COLUMNS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (byte_data),
        .push   (push)
    );

    udlc_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (byte_stall),
        .level (level),
        .valid (rec_valid),
        .stall (rec_stall),
        .data  (rec_data)
    );

    a_summary_queued: assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_data.end_of_input |=> rec_valid)
        else $error("end of input left no record");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        level <= ($clog2(UDLC_FIFO_DEPTH) + 1)'(UDLC_FIFO_DEPTH))
        else $error("result queue overflow");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && !rec_stall && level == 1 && !accept |=> !rec_valid)
        else $error("record repeated after last transfer");

endmodule
